>>> sv/cbts_pkg.sv
// package: shared types, constants and the segment table of the can bit timing search
`default_nettype none
package cbts_pkg;

  localparam int unsigned RATE_W  = 20;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned QUANT_W = 5;
  localparam int unsigned REM_W   = RATE_W + 1;

  localparam logic [QUANT_W-1:0] MAX_QUANTA = 5'd25;
  localparam logic [QUANT_W-1:0] MIN_QUANTA = 5'd4;

  // four quotient bits per cycle, 32 quotient bits per division
  localparam int unsigned        BITS_PER_STEP = 4;
  localparam logic [2:0]         DIV_LAST      = 3'd7;

  localparam logic [WORD_W-1:0]  NOT_FOUND_WORD  = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0]  CLOCK_HZ_RESET  = 32'd42000000;
  localparam logic [1:0]         JUMP_WIDTH_RESET = 2'd1;

  localparam logic [0:0] REG_CLOCK_HZ   = 1'b0;
  localparam logic [0:0] REG_JUMP_WIDTH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_W,
    ST_SAVE_W,
    ST_DIV_Q,
    ST_CHECK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic save_w;
    logic check;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic rate_zero;
    logic div_last;
    logic match;
    logic q_min;
  } sts_t;

  typedef struct packed {
    logic [3:0] s1;
    logic [2:0] s2;
  } seg_t;

  function automatic seg_t seg_split(input logic [QUANT_W-1:0] q);
    seg_t s;
    unique case (q)
      5'd3:    s = '{s1: 4'h0, s2: 3'h0};
      5'd4:    s = '{s1: 4'h1, s2: 3'h0};
      5'd5:    s = '{s1: 4'h2, s2: 3'h0};
      5'd6:    s = '{s1: 4'h2, s2: 3'h1};
      5'd7:    s = '{s1: 4'h3, s2: 3'h1};
      5'd8:    s = '{s1: 4'h4, s2: 3'h1};
      5'd9:    s = '{s1: 4'h4, s2: 3'h2};
      5'd10:   s = '{s1: 4'h5, s2: 3'h2};
      5'd11:   s = '{s1: 4'h6, s2: 3'h2};
      5'd12:   s = '{s1: 4'h7, s2: 3'h2};
      5'd13:   s = '{s1: 4'h7, s2: 3'h3};
      5'd14:   s = '{s1: 4'h8, s2: 3'h3};
      5'd15:   s = '{s1: 4'h9, s2: 3'h3};
      5'd16:   s = '{s1: 4'hA, s2: 3'h3};
      5'd17:   s = '{s1: 4'hA, s2: 3'h4};
      5'd18:   s = '{s1: 4'hB, s2: 3'h4};
      5'd19:   s = '{s1: 4'hC, s2: 3'h4};
      5'd20:   s = '{s1: 4'hD, s2: 3'h4};
      5'd21:   s = '{s1: 4'hD, s2: 3'h5};
      5'd22:   s = '{s1: 4'hE, s2: 3'h5};
      5'd23:   s = '{s1: 4'hF, s2: 3'h5};
      5'd24:   s = '{s1: 4'hF, s2: 3'h6};
      5'd25:   s = '{s1: 4'hF, s2: 3'h7};
      default: s = '{s1: 4'h0, s2: 3'h0};
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

>>> sv/cbts_if.sv
// interfaces: bit rate request channel and timing result channel
`default_nettype none
interface cbts_req_if;
  logic        valid;
  logic        ready;
  logic [19:0] bit_rate;
  modport source (output valid, output bit_rate, input ready);
  modport sink (input valid, input bit_rate, output ready);
endinterface

interface cbts_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] timing_word;
  logic [9:0]  prescaler_minus_one;
  logic [3:0]  segment_one;
  logic [2:0]  segment_two;
  modport source (output valid, output found, output timing_word,
                  output prescaler_minus_one, output segment_one,
                  output segment_two, input ready);
  modport sink (input valid, input found, input timing_word,
                input prescaler_minus_one, input segment_one,
                input segment_two, output ready);
endinterface
`default_nettype wire

>>> sv/can_bit_timing_search_core.sv
// top level: can bit timing prescaler search with apb configuration
//
//   channel   dir   beat contents
//   req       in    bit_rate
//   rsp       out   found, timing_word, prescaler_minus_one, segment_one, segment_two
//   apb       in    clock_hz (0x0), jump_width (0x4)
//
// one request at a time: accept, the division clock_hz / bit_rate,
// then a divider pass plus a check per quanta count tried, 25 down to 4
// a zero rate skips the divisions; every division runs on the shared divider
// the result register frees the search while a beat waits on rsp.ready
// synchronous reset restores clock_hz and jump_width and empties the result register
`default_nettype none
module can_bit_timing_search_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  cbts_req_if.sink         req,
  cbts_rsp_if.source       rsp
);

  logic [31:0]    clock_hz;
  logic [1:0]     jump_width;
  cbts_pkg::cmd_t cmd;
  cbts_pkg::sts_t sts;

  cbts_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .clock_hz   (clock_hz),
    .jump_width (jump_width)
  );

  cbts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_ready (rsp.ready),
    .rsp_valid (rsp.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  cbts_dp u_dp (
    .clk                 (clk),
    .bit_rate            (req.bit_rate),
    .clock_hz            (clock_hz),
    .jump_width          (jump_width),
    .cmd                 (cmd),
    .sts                 (sts),
    .found               (rsp.found),
    .timing_word         (rsp.timing_word),
    .prescaler_minus_one (rsp.prescaler_minus_one),
    .segment_one         (rsp.segment_one),
    .segment_two         (rsp.segment_two)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while a search is running");

  a_not_found_word: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.found) |-> (rsp.timing_word == cbts_pkg::NOT_FOUND_WORD))
    else $error("not-found beat without all-ones timing word");

  a_found_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.found) |->
      (rsp.timing_word[9:0] == rsp.prescaler_minus_one &&
       rsp.timing_word[19:16] == rsp.segment_one &&
       rsp.timing_word[22:20] == rsp.segment_two))
    else $error("timing word disagrees with its fields");

endmodule
`default_nettype wire

>>> sv/cbts_regs.sv
// apb configuration registers: peripheral clock and jump width
`default_nettype none
module cbts_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [31:0]      clock_hz,
  output logic [1:0]       jump_width
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz   <= cbts_pkg::CLOCK_HZ_RESET;
      jump_width <= cbts_pkg::JUMP_WIDTH_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        cbts_pkg::REG_CLOCK_HZ:   clock_hz   <= pwdata;
        cbts_pkg::REG_JUMP_WIDTH: jump_width <= pwdata[1:0];
        default:                  clock_hz   <= clock_hz;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      cbts_pkg::REG_CLOCK_HZ:   prdata = clock_hz;
      cbts_pkg::REG_JUMP_WIDTH: prdata = {30'd0, jump_width};
      default:                  prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/cbts_ctrl.sv
// controller: sequences the rate division, the quanta search and the result beat
`default_nettype none
module cbts_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire logic            rsp_ready,
  output logic                 rsp_valid,
  input  wire cbts_pkg::sts_t  sts,
  output cbts_pkg::cmd_t       cmd
);

  cbts_pkg::state_t state, state_next;
  logic             rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cbts_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      cbts_pkg::ST_IDLE: begin
        req_ready = !rst;
        if (req_valid && req_ready) begin
          cmd.accept = 1'b1;
          state_next = sts.rate_zero ? cbts_pkg::ST_FINISH : cbts_pkg::ST_DIV_W;
        end
      end
      cbts_pkg::ST_DIV_W: begin
        cmd.step = 1'b1;
        if (sts.div_last) state_next = cbts_pkg::ST_SAVE_W;
      end
      cbts_pkg::ST_SAVE_W: begin
        cmd.save_w = 1'b1;
        state_next = cbts_pkg::ST_DIV_Q;
      end
      cbts_pkg::ST_DIV_Q: begin
        cmd.step = 1'b1;
        if (sts.div_last) state_next = cbts_pkg::ST_CHECK;
      end
      cbts_pkg::ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = (sts.match || sts.q_min) ? cbts_pkg::ST_FINISH : cbts_pkg::ST_DIV_Q;
      end
      cbts_pkg::ST_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.emit   = 1'b1;
          state_next = cbts_pkg::ST_IDLE;
        end
      end
      default: state_next = cbts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) rsp_valid_next = 1'b1;
    else if (rsp_ready) rsp_valid_next = 1'b0;
    else rsp_valid_next = rsp_valid;
  end

endmodule
`default_nettype wire

>>> sv/cbts_dp.sv
// datapath: radix-16 divider, range check, segment lookup and result register
`default_nettype none
module cbts_dp (
  input  wire logic                 clk,
  input  wire logic [19:0]          bit_rate,
  input  wire logic [31:0]          clock_hz,
  input  wire logic [1:0]           jump_width,
  input  wire cbts_pkg::cmd_t       cmd,
  output cbts_pkg::sts_t            sts,
  output logic                      found,
  output logic [31:0]               timing_word,
  output logic [9:0]                prescaler_minus_one,
  output logic [3:0]                segment_one,
  output logic [2:0]                segment_two
);

  localparam int unsigned RW = cbts_pkg::REM_W;

  logic [31:0]   num, num_next;
  logic [19:0]   den;
  logic [RW-1:0] rem, rem_next;
  logic [31:0]   quo, quo_next;
  logic [2:0]    cnt;
  logic [31:0]   w;
  logic [4:0]    q;
  logic          hit;
  logic [9:0]    presc;
  logic [4:0]    sel_q;

  logic [31:0]   dm1;
  logic [36:0]   lo_prod;
  logic          lo_ok;
  logic          hi_ok;
  cbts_pkg::seg_t seg;

  // four restoring steps per cycle
  always_comb begin
    logic [RW-1:0] r;
    logic [RW-1:0] t;
    logic [31:0]   n;
    logic [31:0]   qq;
    r = rem;
    n = num;
    qq = quo;
    for (int i = 0; i < cbts_pkg::BITS_PER_STEP; i++) begin
      t = {r[RW-2:0], n[31]};
      n = {n[30:0], 1'b0};
      if (t >= {1'b0, den}) begin
        r  = t - {1'b0, den};
        qq = {qq[30:0], 1'b1};
      end else begin
        r  = t;
        qq = {qq[30:0], 1'b0};
      end
    end
    rem_next = r;
    num_next = n;
    quo_next = qq;
  end

  // divider window: w/24 + 2 <= d <= w/4 + 1, written without dividing
  assign dm1     = quo - 32'd1;
  assign lo_prod = {1'b0, dm1, 4'b0} + {2'b0, dm1, 3'b0};
  assign lo_ok   = (quo >= 32'd2) && (lo_prod > {5'd0, w});
  assign hi_ok   = (quo == 32'd0) || ({dm1, 2'b0} <= {2'b0, w});

  assign sts.rate_zero = (bit_rate == 20'd0);
  assign sts.div_last  = (cnt == cbts_pkg::DIV_LAST);
  assign sts.match     = (rem == '0) && lo_ok && hi_ok;
  assign sts.q_min     = (q == cbts_pkg::MIN_QUANTA);

  assign seg = cbts_pkg::seg_split(sel_q);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      num <= clock_hz;
      den <= bit_rate;
      rem <= '0;
      cnt <= '0;
      hit <= 1'b0;
    end else if (cmd.step) begin
      num <= num_next;
      rem <= rem_next;
      quo <= quo_next;
      cnt <= cnt + 3'd1;
    end else if (cmd.save_w) begin
      w   <= quo;
      num <= quo;
      den <= {15'd0, cbts_pkg::MAX_QUANTA};
      q   <= cbts_pkg::MAX_QUANTA;
      rem <= '0;
      cnt <= '0;
    end else if (cmd.check) begin
      if (sts.match) begin
        hit   <= 1'b1;
        presc <= dm1[9:0];
        sel_q <= q;
      end
      num <= w;
      den <= {15'd0, q - 5'd1};
      q   <= q - 5'd1;
      rem <= '0;
      cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      found <= hit;
      if (hit) begin
        timing_word         <= {6'd0, jump_width, 1'b0, seg.s2, seg.s1, 6'd0, presc};
        prescaler_minus_one <= presc;
        segment_one         <= seg.s1;
        segment_two         <= seg.s2;
      end else begin
        timing_word         <= cbts_pkg::NOT_FOUND_WORD;
        prescaler_minus_one <= '0;
        segment_one         <= '0;
        segment_two         <= '0;
      end
    end
  end

endmodule
`default_nettype wire
